// ===== hw/rtl/otwg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otwg_pkg
// Shared types and constants of the overlapping tile window generator.
// ----------------------------------------------------------------------------
package otwg_pkg;

    localparam int COORD_BITS         = 16;
    localparam int MAX_TILES_DEFAULT  = 8;
    localparam int THR_BITS           = 17;
    localparam int MUL_W              = 17;
    localparam int PROD_W             = 2 * MUL_W;
    localparam int ADDR_W             = 4;
    localparam int DATA_W             = 32;

    localparam logic [1:0] REG_WINDOW_SIZE    = 2'd0;
    localparam logic [1:0] REG_WINDOW_GAP     = 2'd1;
    localparam logic [1:0] REG_AREA_THRESHOLD = 2'd2;

    localparam logic [COORD_BITS-1:0] WINDOW_SIZE_RESET    = 16'd1024;
    localparam logic [COORD_BITS-1:0] WINDOW_GAP_RESET     = 16'd200;
    localparam logic [THR_BITS-1:0]   AREA_THRESHOLD_RESET = 17'd39322;

    localparam logic [1:0] OUTCOME_WINDOW    = 2'd0;
    localparam logic [1:0] OUTCOME_EMPTY     = 2'd1;
    localparam logic [1:0] OUTCOME_BAD_GAP   = 2'd2;
    localparam logic [1:0] OUTCOME_TRUNCATED = 2'd3;

    typedef struct packed {
        logic [COORD_BITS-1:0] image_width;
        logic [COORD_BITS-1:0] image_height;
    } in_word_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] left_edge;
        logic [COORD_BITS-1:0] top_edge;
        logic [COORD_BITS-1:0] right_edge;
        logic [COORD_BITS-1:0] bottom_edge;
        logic [1:0]            outcome;
        logic                  last_of_image;
    } out_word_t;

endpackage

// ===== hw/rtl/otwg_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otwg_mul
// Shared unsigned multiplier with a registered product, one result a cycle.
// ----------------------------------------------------------------------------
module otwg_mul
    import otwg_pkg::*;
(
    input  logic              clk,
    input  logic [MUL_W-1:0]  op_a,
    input  logic [MUL_W-1:0]  op_b,
    output logic [PROD_W-1:0] product
);

    logic [PROD_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= op_a * op_b;
    end

    assign product = product_reg;

endmodule

// ===== hw/rtl/overlapping_tile_window_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overlapping_tile_window_generator_unit
// Emits the overlapping square crop windows that tile one image.
// ----------------------------------------------------------------------------
// One image word is taken while the unit is idle. It then counts the windows
// of each axis with one shared accumulator, one candidate start a cycle (up to
// MAX_TILES_PER_AXIS starts per axis), runs the area-fraction test through one
// shared 17x17 multiplier followed by a sum step and a compare step, and
// finally hands out one result word a cycle while out_ready is high. An image
// gives at most MAX_TILES_PER_AXIS squared windows; a bad gap gives a single
// word. in_ready stays low until the last word is loaded for output.
// ----------------------------------------------------------------------------
module overlapping_tile_window_generator_unit
    import otwg_pkg::*;
#(
    parameter int MAX_TILES_PER_AXIS = MAX_TILES_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_word_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_word_t         out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int CNT_W = $clog2(MAX_TILES_PER_AXIS + 1);
    localparam int ACC_W = COORD_BITS + 2;
    localparam int AREA_W = 2 * COORD_BITS;
    localparam int RHS_W = PROD_W + COORD_BITS;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_COUNT  = 7'b0000010,
        ST_MUL    = 7'b0000100,
        ST_SUM    = 7'b0001000,
        ST_CMP    = 7'b0010000,
        ST_EMIT   = 7'b0100000,
        ST_SINGLE = 7'b1000000
    } state_t;

    logic [COORD_BITS-1:0] size_reg;
    logic [COORD_BITS-1:0] gap_reg;
    logic [THR_BITS-1:0]   thr_reg;

    state_t                state_reg, state_next;
    logic [COORD_BITS-1:0] w_reg, w_next;
    logic [COORD_BITS-1:0] h_reg, h_next;
    logic                  axis_reg, axis_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [CNT_W-1:0]      nx_reg, nx_next;
    logic [CNT_W-1:0]      ny_reg, ny_next;
    logic                  tx_reg, tx_next;
    logic                  ty_reg, ty_next;
    logic [2:0]            phase_reg, phase_next;
    logic [AREA_W-1:0]     area_reg, area_next;
    logic [AREA_W-1:0]     win_reg, win_next;
    logic [PROD_W-1:0]     plo_reg, plo_next;
    logic [PROD_W-1:0]     phi_reg, phi_next;
    logic [RHS_W-1:0]      rhs_reg, rhs_next;
    logic [1:0]            single_reg, single_next;
    logic [CNT_W-1:0]      col_reg, col_next;
    logic [CNT_W-1:0]      row_reg, row_next;
    logic [COORD_BITS-1:0] col_start_reg, col_start_next;
    logic [COORD_BITS-1:0] row_start_reg, row_start_next;
    logic                  out_valid_reg, out_valid_next;
    out_word_t             out_data_reg, out_data_next;

    logic [COORD_BITS-1:0] step;
    logic [COORD_BITS-1:0] clip_x;
    logic [COORD_BITS-1:0] clip_y;
    logic [COORD_BITS-1:0] len;
    logic [ACC_W-1:0]      reach;
    logic [MUL_W-1:0]      op_a;
    logic [MUL_W-1:0]      op_b;
    logic [PROD_W-1:0]     product;
    logic                  slot_free;
    logic                  last_col;
    logic                  last_row;
    logic [COORD_BITS-1:0] left;
    logic [COORD_BITS-1:0] top;
    logic [1:0]            cfg_index;

    assign cfg_index = paddr[ADDR_W-1:2];
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= WINDOW_SIZE_RESET;
            gap_reg  <= WINDOW_GAP_RESET;
            thr_reg  <= AREA_THRESHOLD_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (cfg_index)
                REG_WINDOW_SIZE:    size_reg <= pwdata[COORD_BITS-1:0];
                REG_WINDOW_GAP:     gap_reg  <= pwdata[COORD_BITS-1:0];
                REG_AREA_THRESHOLD: thr_reg  <= pwdata[THR_BITS-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_WINDOW_SIZE:    prdata = DATA_W'(size_reg);
            REG_WINDOW_GAP:     prdata = DATA_W'(gap_reg);
            REG_AREA_THRESHOLD: prdata = DATA_W'(thr_reg);
            default:            prdata = '0;
        endcase
    end

    assign step      = size_reg - gap_reg;
    assign clip_x    = (w_reg < size_reg) ? w_reg : size_reg;
    assign clip_y    = (h_reg < size_reg) ? h_reg : size_reg;
    assign len       = axis_reg ? h_reg : w_reg;
    assign reach     = acc_reg + ACC_W'(size_reg);
    assign slot_free = !out_valid_reg || out_ready;
    assign last_col  = (col_reg == CNT_W'(nx_reg - 1'b1));
    assign last_row  = (row_reg == CNT_W'(ny_reg - 1'b1));
    assign left      = (last_col && nx_reg != CNT_W'(1) && !tx_reg)
                       ? (w_reg - size_reg) : col_start_reg;
    assign top       = (last_row && ny_reg != CNT_W'(1) && !ty_reg)
                       ? (h_reg - size_reg) : row_start_reg;

    always_comb
    begin
        case (phase_reg)
            3'd0:
            begin
                op_a = MUL_W'(clip_x);
                op_b = MUL_W'(clip_y);
            end
            3'd1:
            begin
                op_a = MUL_W'(size_reg);
                op_b = MUL_W'(size_reg);
            end
            3'd2:
            begin
                op_a = MUL_W'(thr_reg);
                op_b = MUL_W'(product[COORD_BITS-1:0]);
            end
            3'd3:
            begin
                op_a = MUL_W'(thr_reg);
                op_b = MUL_W'(win_reg[AREA_W-1:COORD_BITS]);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    otwg_mul u_mul (
        .clk     (clk),
        .op_a    (op_a),
        .op_b    (op_b),
        .product (product)
    );

    always_comb
    begin
        state_next     = state_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        axis_next      = axis_reg;
        acc_next       = acc_reg;
        n_next         = n_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        phase_next     = phase_reg;
        area_next      = area_reg;
        win_next       = win_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        rhs_next       = rhs_reg;
        single_next    = single_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        col_start_next = col_start_reg;
        row_start_next = row_start_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    w_next = in_data.image_width;
                    h_next = in_data.image_height;
                    if (gap_reg >= size_reg)
                    begin
                        single_next = OUTCOME_BAD_GAP;
                        state_next  = ST_SINGLE;
                    end
                    else
                    begin
                        axis_next  = 1'b0;
                        acc_next   = '0;
                        n_next     = CNT_W'(1);
                        state_next = ST_COUNT;
                    end
                end
            end
            ST_COUNT:
            begin
                if (reach >= ACC_W'(len) || n_reg == CNT_W'(MAX_TILES_PER_AXIS))
                begin
                    acc_next = '0;
                    n_next   = CNT_W'(1);
                    if (!axis_reg)
                    begin
                        nx_next   = n_reg;
                        tx_next   = (reach < ACC_W'(len));
                        axis_next = 1'b1;
                    end
                    else
                    begin
                        ny_next    = n_reg;
                        ty_next    = (reach < ACC_W'(len));
                        phase_next = 3'd0;
                        state_next = ST_MUL;
                    end
                end
                else
                begin
                    acc_next = acc_reg + ACC_W'(step);
                    n_next   = n_reg + 1'b1;
                end
            end
            ST_MUL:
            begin
                phase_next = phase_reg + 3'd1;
                case (phase_reg)
                    3'd1:    area_next = product[AREA_W-1:0];
                    3'd2:    win_next  = product[AREA_W-1:0];
                    3'd3:    plo_next  = product;
                    3'd4:
                    begin
                        phi_next   = product;
                        state_next = ST_SUM;
                    end
                    default: ;
                endcase
            end
            ST_SUM:
            begin
                rhs_next   = RHS_W'(plo_reg) + {phi_reg, {COORD_BITS{1'b0}}};
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (RHS_W'({area_reg, {COORD_BITS{1'b0}}}) >= rhs_reg)
                begin
                    col_next       = '0;
                    row_next       = '0;
                    col_start_next = '0;
                    row_start_next = '0;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    single_next = OUTCOME_EMPTY;
                    state_next  = ST_SINGLE;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.left_edge     = left;
                    out_data_next.top_edge      = top;
                    out_data_next.right_edge    = left + size_reg;
                    out_data_next.bottom_edge   = top + size_reg;
                    out_data_next.last_of_image = last_col && last_row;
                    out_data_next.outcome       = (last_col && last_row && (tx_reg || ty_reg))
                                                  ? OUTCOME_TRUNCATED : OUTCOME_WINDOW;
                    if (last_row)
                    begin
                        row_next       = '0;
                        row_start_next = '0;
                        col_next       = col_reg + 1'b1;
                        col_start_next = col_start_reg + step;
                        if (last_col)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        row_next       = row_reg + 1'b1;
                        row_start_next = row_start_reg + step;
                    end
                end
            end
            ST_SINGLE:
            begin
                if (slot_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.left_edge     = '0;
                    out_data_next.top_edge      = '0;
                    out_data_next.right_edge    = '0;
                    out_data_next.bottom_edge   = '0;
                    out_data_next.outcome       = single_reg;
                    out_data_next.last_of_image = 1'b1;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg         <= w_next;
        h_reg         <= h_next;
        axis_reg      <= axis_next;
        acc_reg       <= acc_next;
        n_reg         <= n_next;
        nx_reg        <= nx_next;
        ny_reg        <= ny_next;
        tx_reg        <= tx_next;
        ty_reg        <= ty_next;
        phase_reg     <= phase_next;
        area_reg      <= area_next;
        win_reg       <= win_next;
        plo_reg       <= plo_next;
        phi_reg       <= phi_next;
        rhs_reg       <= rhs_next;
        single_reg    <= single_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        col_start_reg <= col_start_next;
        row_start_reg <= row_start_next;
        out_data_reg  <= out_data_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
